// ===== design/tsrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrl_pkg: shared types for the tag selection rate limiter
// Operation codes, the packet that walks the cell chain, and one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrl_pkg;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_ERASE,
    OP_SAMPLE,
    OP_QUERY
  } op_t;

  // Operation packet handed from cell to cell, one cell per cycle
  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [31:0] tag;
    logic [47:0] now;
    logic [31:0] sep;
    logic        found;    // tag matched in an earlier cell
    logic        claimed;  // an earlier cell took the new tag
    logic        fwd;      // sample forwarded
    logic        shift;    // erase in progress: cells pull from their neighbor
  } pkt_t;

  // Contents of one cell, also seen by the cell in front of it
  typedef struct packed {
    logic        valid;
    logic        emitted;
    logic [31:0] tag;
    logic [47:0] last;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/tsrl_cell.sv =====
// ----------------------------------------------------------------------------
// tsrl_cell: one table entry of the selection chain
// Processes the operation packet in its cycle and registers it for the next
// cell. Valid entries stay packed at the front of the chain: an erase pulls
// every later entry one cell forward.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrl_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tsrl_pkg::pkt_t  pkt_i,
  input  wire tsrl_pkg::entry_t nb_i,
  output tsrl_pkg::pkt_t       pkt_o,
  output tsrl_pkg::entry_t     ent_o
);

  logic        valid_r,   valid_nxt;
  logic        emitted_r, emitted_nxt;
  logic [31:0] tag_r,     tag_nxt;
  logic [47:0] last_r,    last_nxt;
  tsrl_pkg::pkt_t pkt_r,  pkt_nxt;

  logic        hit;
  logic [48:0] diff;
  logic        too_soon;

  always_comb begin
    hit      = pkt_i.vld && valid_r && (tag_r == pkt_i.tag);
    diff     = {1'b0, pkt_i.now} - {1'b0, last_r};
    too_soon = emitted_r && (pkt_i.sep != 32'd0) &&
               (diff[48] || (diff[47:0] < {16'd0, pkt_i.sep}));

    valid_nxt   = valid_r;
    emitted_nxt = emitted_r;
    tag_nxt     = tag_r;
    last_nxt    = last_r;
    pkt_nxt     = pkt_i;

    if (pkt_i.vld) begin
      case (pkt_i.op)
        tsrl_pkg::OP_ADD: begin
          if (hit) begin
            pkt_nxt.found = 1'b1;
          end else if (!valid_r && !pkt_i.found && !pkt_i.claimed) begin
            // first free cell sits right after the packed valid entries
            valid_nxt       = 1'b1;
            emitted_nxt     = 1'b0;
            tag_nxt         = pkt_i.tag;
            pkt_nxt.claimed = 1'b1;
          end
        end
        tsrl_pkg::OP_ERASE: begin
          if (pkt_i.shift || hit) begin
            valid_nxt     = nb_i.valid;
            emitted_nxt   = nb_i.emitted;
            tag_nxt       = nb_i.tag;
            last_nxt      = nb_i.last;
            pkt_nxt.found = 1'b1;
            pkt_nxt.shift = 1'b1;
          end
        end
        tsrl_pkg::OP_SAMPLE: begin
          if (hit) begin
            pkt_nxt.found = 1'b1;
            if (!too_soon) begin
              emitted_nxt = 1'b1;
              last_nxt    = pkt_i.now;
              pkt_nxt.fwd = 1'b1;
            end
          end
        end
        default: begin
          if (hit) begin
            pkt_nxt.found = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      emitted_r <= 1'b0;
      pkt_r     <= '0;
    end else begin
      valid_r   <= valid_nxt;
      emitted_r <= emitted_nxt;
      pkt_r     <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    last_r <= last_nxt;
  end

  assign pkt_o = pkt_r;
  assign ent_o = '{valid: valid_r, emitted: emitted_r, tag: tag_r, last: last_r};

endmodule

`default_nettype wire

// ===== design/tag_selection_rate_limiter.sv =====
// ----------------------------------------------------------------------------
// tag_selection_rate_limiter: selected tag table with per-tag rate limiting
// Channel  | Handshake                 | Payload
// input    | start & !busy             | in_mode, in_tag_id, in_tag_id_high, in_now_ms
// result   | out_valid (one cycle)     | out_forward, out_present, out_entry_count,
//          |                           | out_table_full
// config   | psel & penable & pwrite   | paddr, pwdata, prdata (pready tied high)
//
// Each operation walks the chain of TABLE_ENTRIES cells, one cell per cycle;
// a range add runs one walk per id.
// busy stays high during the walk; results cannot be held off by the receiver.
// Reset is synchronous and empties the table at once.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_selection_rate_limiter #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_mode,
  input  wire logic signed [31:0] in_tag_id,
  input  wire logic signed [31:0] in_tag_id_high,
  input  wire logic [47:0]        in_now_ms,
  output logic                    out_valid,
  output logic                    out_forward,
  output logic                    out_present,
  output logic [6:0]              out_entry_count,
  output logic                    out_table_full,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] MODE_ADD    = 3'd0;
  localparam logic [2:0] MODE_ERASE  = 3'd1;
  localparam logic [2:0] MODE_RANGE  = 3'd2;
  localparam logic [2:0] MODE_SAMPLE = 3'd4;

  localparam logic REG_DEFAULT  = 1'b0;
  localparam logic REG_OVERRIDE = 1'b1;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  // configuration port
  logic [31:0] cfg_default_sep_r;
  logic [31:0] cfg_override_sep_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_OVERRIDE) ? cfg_override_sep_r : cfg_default_sep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_default_sep_r  <= 32'd0;
      cfg_override_sep_r <= 32'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEFAULT) begin
        cfg_default_sep_r <= pwdata;
      end else begin
        cfg_override_sep_r <= pwdata;
      end
    end
  end

  // cell chain
  tsrl_pkg::pkt_t   pk  [TABLE_ENTRIES+1];
  tsrl_pkg::entry_t ent [TABLE_ENTRIES+1];
  tsrl_pkg::pkt_t   launch_r, launch_nxt;

  assign pk[0]              = launch_r;
  assign ent[TABLE_ENTRIES] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    tsrl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .pkt_i (pk[g]),
      .nb_i  (ent[g+1]),
      .pkt_o (pk[g+1]),
      .ent_o (ent[g])
    );
  end

  // sequencer
  state_t          state_r,  state_nxt;
  tsrl_pkg::op_t   op_r,     op_nxt;
  logic            range_r,  range_nxt;
  logic            first_r,  first_nxt;
  logic            pres_r,   pres_nxt;
  logic [31:0]     tag_r,    tag_nxt;
  logic [31:0]     hi_r,     hi_nxt;
  logic [47:0]     now_r,    now_nxt;
  logic [31:0]     sep_r,    sep_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic            out_valid_r,   out_valid_nxt;
  logic            out_forward_r, out_forward_nxt;
  logic            out_present_r, out_present_nxt;
  logic [6:0]      out_count_r,   out_count_nxt;
  logic            out_full_r,    out_full_nxt;

  tsrl_pkg::pkt_t  exit_p;
  logic            dropped;
  logic            hit_now;

  assign exit_p = pk[TABLE_ENTRIES];

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    range_nxt       = range_r;
    first_nxt       = first_r;
    pres_nxt        = pres_r;
    tag_nxt         = tag_r;
    hi_nxt          = hi_r;
    now_nxt         = now_r;
    sep_nxt         = sep_r;
    cnt_nxt         = cnt_r;
    launch_nxt      = '0;
    out_valid_nxt   = 1'b0;
    out_forward_nxt = out_forward_r;
    out_present_nxt = out_present_r;
    out_count_nxt   = out_count_r;
    out_full_nxt    = out_full_r;
    dropped         = 1'b0;
    hit_now         = exit_p.found || exit_p.claimed;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          range_nxt = 1'b0;
          first_nxt = 1'b1;
          tag_nxt   = in_tag_id;
          hi_nxt    = in_tag_id_high;
          now_nxt   = in_now_ms;
          sep_nxt   = (cfg_override_sep_r != 32'd0) ? cfg_override_sep_r
                                                    : cfg_default_sep_r;
          case (in_mode)
            MODE_ADD:    op_nxt = tsrl_pkg::OP_ADD;
            MODE_ERASE:  op_nxt = tsrl_pkg::OP_ERASE;
            MODE_RANGE: begin
              // empty range only reports membership of the low id
              if (in_tag_id > in_tag_id_high) begin
                op_nxt = tsrl_pkg::OP_QUERY;
              end else begin
                op_nxt    = tsrl_pkg::OP_ADD;
                range_nxt = 1'b1;
              end
            end
            MODE_SAMPLE: op_nxt = tsrl_pkg::OP_SAMPLE;
            default:     op_nxt = tsrl_pkg::OP_QUERY;
          endcase
          launch_nxt.vld = 1'b1;
          launch_nxt.op  = op_nxt;
          launch_nxt.tag = tag_nxt;
          launch_nxt.now = now_nxt;
          launch_nxt.sep = sep_nxt;
          state_nxt      = S_RUN;
        end
      end
      S_RUN: begin
        if (exit_p.vld) begin
          dropped = (op_r == tsrl_pkg::OP_ADD) && !hit_now;
          if ((op_r == tsrl_pkg::OP_ADD) && exit_p.claimed) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else if ((op_r == tsrl_pkg::OP_ERASE) && exit_p.found) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          if (first_r) begin
            pres_nxt = hit_now;
          end
          if (range_r && !dropped && (tag_r != hi_r)) begin
            // advance to the next id of the range
            tag_nxt        = tag_r + 32'd1;
            first_nxt      = 1'b0;
            launch_nxt.vld = 1'b1;
            launch_nxt.op  = tsrl_pkg::OP_ADD;
            launch_nxt.tag = tag_nxt;
            launch_nxt.now = now_r;
            launch_nxt.sep = sep_r;
          end else begin
            out_valid_nxt   = 1'b1;
            out_forward_nxt = exit_p.fwd;
            case (op_r)
              tsrl_pkg::OP_ADD:   out_present_nxt = first_r ? hit_now : pres_r;
              tsrl_pkg::OP_ERASE: out_present_nxt = 1'b0;
              default:            out_present_nxt = exit_p.found;
            endcase
            out_count_nxt = 7'(cnt_nxt);
            out_full_nxt  = dropped;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      launch_r      <= launch_nxt;
      out_valid_r   <= out_valid_nxt;
      op_r          <= op_nxt;
      range_r       <= range_nxt;
      first_r       <= first_nxt;
      pres_r        <= pres_nxt;
      tag_r         <= tag_nxt;
      hi_r          <= hi_nxt;
      now_r         <= now_nxt;
      sep_r         <= sep_nxt;
      out_forward_r <= out_forward_nxt;
      out_present_r <= out_present_nxt;
      out_count_r   <= out_count_nxt;
      out_full_r    <= out_full_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_forward     = out_forward_r;
  assign out_present     = out_present_r;
  assign out_entry_count = out_count_r;
  assign out_table_full  = out_full_r;

endmodule

`default_nettype wire

// ===== bench/tag_selection_rate_limiter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tag_selection_rate_limiter_tb: self-checking bench for the tag rate limiter
// Drives add, erase, range add, query and sample commands through the
// start/busy handshake and predicts every result strobe with a table model
// of its own. Separation registers are rewritten over the APB port between
// phases, including zero and all-ones values, and read back.
// ----------------------------------------------------------------------------

module tag_selection_rate_limiter_tb;

  localparam int TABLE_ENTRIES    = 64;
  localparam int REG_DEFAULT_SEP  = 0;
  localparam int REG_OVERRIDE_SEP = 1;
  localparam int ITEMS_PER_PHASE  = 290;
  localparam int NUM_PHASES       = 6;

  typedef enum bit [2:0] {
    MODE_ADD,
    MODE_ERASE,
    MODE_RANGE,
    MODE_QUERY,
    MODE_SAMPLE,
    MODE_SPARE5,
    MODE_SPARE6,
    MODE_SPARE7
  } mode_t;

  typedef struct packed {
    logic       fwd;
    logic       present;
    logic [6:0] count;
    logic       full;
  } verdict_t;

  // Tag table model plus the queue of verdicts still owed by the block
  class rate_limit_checker;
    bit          slot_valid   [TABLE_ENTRIES];
    logic [31:0] slot_tag     [TABLE_ENTRIES];
    bit          slot_emitted [TABLE_ENTRIES];
    logic [47:0] slot_last    [TABLE_ENTRIES];
    int          selected;
    logic [31:0] default_sep;
    logic [31:0] override_sep;
    verdict_t    owed_verdicts[$];
    int          errors;
    int          results_seen;

    function new();
      selected     = 0;
      default_sep  = '0;
      override_sep = '0;
      errors       = 0;
      results_seen = 0;
    endfunction

    function int find_slot(logic [31:0] tag);
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot_valid[i] && slot_tag[i] == tag) return i;
      return -1;
    endfunction

    // Returns 1 when the tag was dropped for lack of a free slot
    function bit claim_slot(logic [31:0] tag);
      if (find_slot(tag) >= 0) return 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (!slot_valid[i]) begin
          slot_valid[i]   = 1'b1;
          slot_tag[i]     = tag;
          slot_emitted[i] = 1'b0;
          slot_last[i]    = '0;
          selected++;
          return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function logic [31:0] live_tag();
      int picks[$];
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (slot_valid[i]) picks.push_back(i);
      if (picks.size() == 0) return $urandom;
      return slot_tag[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction

    function void note_transfer(bit [2:0] mode, logic [31:0] tag, logic [31:0] tag_hi,
                                logic [47:0] now);
      verdict_t    v;
      int          slot;
      logic [31:0] sep;
      longint      lo_id;
      longint      hi_id;
      longint      id;
      bit          ok;
      v = '0;
      case (mode)
        MODE_ADD: v.full = claim_slot(tag);
        MODE_ERASE: begin
          slot = find_slot(tag);
          if (slot >= 0) begin
            slot_valid[slot]   = 1'b0;
            slot_emitted[slot] = 1'b0;
            selected--;
          end
        end
        MODE_RANGE: begin
          lo_id = $signed(tag);
          hi_id = $signed(tag_hi);
          // stop at the first drop: every later absent id would drop too
          for (id = lo_id; id <= hi_id; id++) begin
            if (claim_slot(id[31:0])) begin
              v.full = 1'b1;
              break;
            end
          end
        end
        MODE_SAMPLE: begin
          slot = find_slot(tag);
          if (slot >= 0) begin
            sep = (override_sep != 0) ? override_sep : default_sep;
            ok  = 1'b1;
            if (slot_emitted[slot] && sep != 0) begin
              if (now < slot_last[slot] || (now - slot_last[slot]) < 48'(sep)) ok = 1'b0;
            end
            if (ok) begin
              slot_last[slot]    = now;
              slot_emitted[slot] = 1'b1;
              v.fwd              = 1'b1;
            end
          end
        end
        default: ; // query and spare codes leave the table alone
      endcase
      v.present = (find_slot(tag) >= 0);
      v.count   = selected[6:0];
      owed_verdicts.push_back(v);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic fwd, logic present, logic [6:0] count, logic full);
      verdict_t want;
      results_seen++;
      if (owed_verdicts.size() == 0) begin
        report($sformatf("result %0d arrived with no command outstanding", results_seen));
        return;
      end
      want = owed_verdicts.pop_front();
      if (fwd !== want.fwd)
        report($sformatf("result %0d forward %b, want %b", results_seen, fwd, want.fwd));
      if (present !== want.present)
        report($sformatf("result %0d present %b, want %b", results_seen, present,
                         want.present));
      if (count !== want.count)
        report($sformatf("result %0d entry_count %0d, want %0d", results_seen, count,
                         want.count));
      if (full !== want.full)
        report($sformatf("result %0d table_full %b, want %b", results_seen, full,
                         want.full));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [2:0]         in_mode;
  logic signed [31:0] in_tag_id;
  logic signed [31:0] in_tag_id_high;
  logic [47:0]        in_now_ms;
  logic               out_valid;
  logic               out_forward;
  logic               out_present;
  logic [6:0]         out_entry_count;
  logic               out_table_full;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  rate_limit_checker  sb;
  bit                 steady;
  logic [47:0]        clock_ms;
  logic [31:0]        eff_sep;
  logic [31:0]        tag_pool[24];

  tag_selection_rate_limiter #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_tag_id       (in_tag_id),
    .in_tag_id_high  (in_tag_id_high),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_forward     (out_forward),
    .out_present     (out_present),
    .out_entry_count (out_entry_count),
    .out_table_full  (out_table_full),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result(out_forward, out_present, out_entry_count, out_table_full);
  end

  task automatic write_reg(int idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_reg(int idx, output logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 3'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    value = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain the block, then load both separation registers and read them back
  task automatic apply_separation(logic [31:0] dflt, logic [31:0] ovr);
    logic [31:0] seen;
    @(negedge clk);
    start <= 1'b0;
    while (sb.owed_verdicts.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (TABLE_ENTRIES + 1) @(posedge clk);
    write_reg(REG_DEFAULT_SEP, dflt);
    write_reg(REG_OVERRIDE_SEP, ovr);
    read_reg(REG_DEFAULT_SEP, seen);
    if (seen !== dflt) sb.report($sformatf("default separation reads %h, want %h", seen, dflt));
    read_reg(REG_OVERRIDE_SEP, seen);
    if (seen !== ovr) sb.report($sformatf("override separation reads %h, want %h", seen, ovr));
    sb.default_sep  = dflt;
    sb.override_sep = ovr;
    eff_sep         = (ovr != 0) ? ovr : dflt;
  endtask

  // Present one command and hold it until the block takes the transfer
  task automatic issue(bit [2:0] mode, logic [31:0] tag, logic [31:0] tag_hi,
                       logic [47:0] now);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < 38) gap = $urandom_range(1, 70);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_tag_id      <= tag;
    in_tag_id_high <= tag_hi;
    in_now_ms      <= now;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_transfer(mode, tag, tag_hi, now);
  endtask

  task automatic random_item();
    bit [2:0]    mode;
    logic [31:0] tag;
    logic [31:0] tag_hi;
    logic [47:0] now;
    logic [63:0] noise;
    longint      hi_id;
    int          r;
    int          erase_w;
    int          cap;
    noise  = {$urandom, $urandom};
    now    = noise[47:0];
    tag_hi = $urandom;
    r = $urandom_range(0, 99);
    if (r < 55 && sb.selected > 0) tag = sb.live_tag();
    else if (r < 90) tag = tag_pool[$urandom_range(0, 23)];
    else tag = $urandom;
    // favor erases when the table runs close to full
    erase_w = (sb.selected > 48) ? 30 : 10;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      mode = MODE_ADD;
    end else if (r < 20 + erase_w) begin
      mode = MODE_ERASE;
    end else if (r < 28 + erase_w) begin
      mode = MODE_RANGE;
      r = $urandom_range(0, 9);
      if (r == 0) begin
        hi_id = $signed(tag) - longint'($urandom_range(1, 1000));
        if (hi_id < -64'sd2147483648) hi_id = -64'sd2147483648;
        tag_hi = hi_id[31:0];
      end else if (r != 1) begin
        hi_id = $signed(tag) + longint'($urandom_range(0, 5));
        if (hi_id > 64'sd2147483647) hi_id = 64'sd2147483647;
        tag_hi = hi_id[31:0];
      end
    end else if (r < 36 + erase_w) begin
      mode = MODE_QUERY;
    end else if (r < 40 + erase_w) begin
      mode = 3'(MODE_SPARE5 + $urandom_range(0, 2));
    end else begin
      mode = MODE_SAMPLE;
      cap  = (eff_sep == 0) ? 5 : ((eff_sep > 150) ? 300 : 2 * int'(eff_sep));
      case ($urandom_range(0, 19))
        0: if (clock_ms > 20) clock_ms = clock_ms - $urandom_range(1, 20);
        1: clock_ms = noise[47:0];
        2, 3, 4: clock_ms = clock_ms + eff_sep;
        5: if (eff_sep != 0) clock_ms = clock_ms + eff_sep - 1;
        default: clock_ms = clock_ms + $urandom_range(0, cap);
      endcase
      now = clock_ms;
    end
    issue(mode, tag, tag_hi, now);
  endtask

  initial begin
    logic [31:0] dflt_tab[NUM_PHASES];
    logic [31:0] ovr_tab[NUM_PHASES];
    dflt_tab = '{32'd0, 32'd37, 32'd200, 32'hFFFF_FFFF, 32'd1, 32'd3};
    ovr_tab  = '{32'd0, 32'd0, 32'd5, 32'd0, 32'hFFFF_FFFF, 32'd1};
    rst_n          = 1'b0;
    start          = 1'b0;
    in_mode        = '0;
    in_tag_id      = '0;
    in_tag_id_high = '0;
    in_now_ms      = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    sb             = new();
    steady         = 1'b0;
    clock_ms       = 48'd1000;
    eff_sep        = '0;
    for (int i = 0; i < 14; i++) tag_pool[i] = i;
    for (int i = 14; i < 22; i++) tag_pool[i] = $urandom;
    tag_pool[22] = 32'h8000_0000;
    tag_pool[23] = 32'h7FFF_FFFF;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    apply_separation(32'd10, 32'd0);
    issue(MODE_QUERY, 32'd5, 32'd0, 48'd0);
    issue(MODE_ADD, 32'd5, 32'd0, 48'd0);
    issue(MODE_ADD, 32'd5, 32'd0, 48'd0);
    issue(MODE_SAMPLE, 32'd5, 32'd0, 48'd100);
    issue(MODE_SAMPLE, 32'd5, 32'd0, 48'd105);
    issue(MODE_SAMPLE, 32'd5, 32'd0, 48'd110);
    issue(MODE_SAMPLE, 32'd5, 32'd0, 48'd50);
    issue(MODE_SAMPLE, 32'd7, 32'd0, 48'd200);
    issue(MODE_ERASE, 32'd9, 32'd0, 48'd0);
    issue(MODE_ERASE, 32'd5, 32'd0, 48'd0);
    issue(MODE_ADD, 32'h8000_0000, 32'd0, 48'd0);
    issue(MODE_ADD, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    issue(MODE_RANGE, 32'd10, 32'd5, 48'd0);
    issue(MODE_RANGE, 32'h7FFF_FFFD, 32'h7FFF_FFFF, 48'd0);
    issue(MODE_RANGE, 32'hFFFF_FFFE, 32'd1, 48'd0);
    issue(MODE_SPARE5, 32'd0, 32'd0, 48'd0);
    issue(MODE_SPARE6, 32'd3, 32'd0, 48'd0);
    issue(MODE_SPARE7, 32'h7FFF_FFFF, 32'd0, 48'd0);
    issue(MODE_SAMPLE, 32'h7FFF_FFFF, 32'd0, 48'hFFFF_FFFF_FFFF);
    // full signed span: fills the table and drops the rest
    issue(MODE_RANGE, 32'h8000_0000, 32'h7FFF_FFFF, 48'd0);
    issue(MODE_ADD, 32'd12345, 32'd0, 48'd0);
    issue(MODE_SAMPLE, 32'h8000_0001, 32'd0, 48'd0);
    issue(MODE_ERASE, 32'h8000_0000, 32'd0, 48'd0);
    issue(MODE_ADD, 32'd12345, 32'd0, 48'd0);
    issue(MODE_QUERY, 32'd12345, 32'd0, 48'd0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      apply_separation(dflt_tab[p], ovr_tab[p]);
      steady = (p == 2);
      repeat (ITEMS_PER_PHASE) random_item();
    end
    steady = 1'b0;

    @(negedge clk);
    start <= 1'b0;
    while (sb.owed_verdicts.size() != 0) @(posedge clk);
    repeat (2 * (TABLE_ENTRIES + 1)) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
